// ----- hw/rtl/dehw_pkg.sv -----
// dehw_pkg: types, field widths, codes and defaults shared by the data element header walker
// no dependencies; compile first
`default_nettype none

package dehw_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int TYPE_W = 56;
    localparam int LEN_W  = 7;
    localparam int HB_W   = 4;

    // default for the longest allowed run of type bytes
    localparam int MAX_TYPE_BYTES = 8;

    // header byte bit positions
    localparam int EXT_BIT = 7;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_TYPE_LONG  = 2'd1;
    localparam logic [1:0] ERR_IN_HEADER  = 2'd2;
    localparam logic [1:0] ERR_IN_PAYLOAD = 2'd3;

    // walker phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    // input request payload
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    // result request payload
    typedef struct packed {
        logic [1:0]        kind;
        logic [TYPE_W-1:0] elem_type;
        logic [LEN_W-1:0]  elem_length;
        logic [HB_W-1:0]   header_bytes;
        logic [BYTE_W-1:0] payload_value;
        logic [1:0]        error_code;
        logic              end_of_buffer;
    } t_out_item;

    // walker handshake toward the stage registers
    typedef struct packed {
        logic take;
        logic res_valid;
    } t_walk_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/dehw_stream_if.sv -----
// dehw_stream_if: valid/ready channel carrying one payload of type T
// depends on nothing; payload types come from dehw_pkg at instantiation
`default_nettype none

interface dehw_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dehw_in_reg.sv -----
// dehw_in_reg: input register holding one buffer byte until the walker takes it
// depends on dehw_pkg
`default_nettype none

module dehw_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  dehw_pkg::t_in_item  i_data,
    output logic                o_ready,
    input  wire                 i_take,
    output logic                o_valid,
    output dehw_pkg::t_in_item  o_data
);

    logic               r_valid;
    dehw_pkg::t_in_item r_data;

    // room when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hw/rtl/dehw_walker.sv -----
// dehw_walker: header/payload state and the single-pass result logic per byte
// depends on dehw_pkg
`default_nettype none

module dehw_walker #(
    parameter int MAX_TYPE_BYTES = dehw_pkg::MAX_TYPE_BYTES
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  dehw_pkg::t_in_item   i_data,
    input  wire                  i_out_free,
    output dehw_pkg::t_walk_ctl  o_ctl,
    output dehw_pkg::t_out_item  o_res
);

    localparam logic [dehw_pkg::HB_W-1:0] MaxCount = dehw_pkg::HB_W'(MAX_TYPE_BYTES);

    dehw_pkg::t_phase                 r_phase, n_phase;
    logic [dehw_pkg::TYPE_W-1:0]      r_type_accum, n_type_accum;
    logic [dehw_pkg::LEN_W-1:0]       r_pending_length, n_pending_length;
    logic [dehw_pkg::HB_W-1:0]        r_type_byte_count, n_type_byte_count;
    logic [dehw_pkg::LEN_W-1:0]       r_payload_left, n_payload_left;

    logic                             res_raw;
    logic                             take;
    logic                             ext;
    logic                             last;
    logic [dehw_pkg::BYTE_W-1:0]      b;
    logic [dehw_pkg::TYPE_W-1:0]      accum_step;
    logic [dehw_pkg::HB_W-1:0]        count_step;
    logic [dehw_pkg::LEN_W-1:0]       left_step;
    logic [dehw_pkg::LEN_W-1:0]       short_len;

    assign b          = i_data.data_byte;
    assign last       = i_data.last_byte;
    assign ext        = b[dehw_pkg::EXT_BIT];
    assign accum_step = {r_type_accum[dehw_pkg::TYPE_W-8:0], b[6:0]};
    assign count_step = r_type_byte_count + 4'd1;
    assign left_step  = r_payload_left - 7'd1;
    assign short_len  = {4'd0, b[6:4]};

    // a byte moves on when its result, if any, has a free slot
    assign take            = i_valid && (!res_raw || i_out_free);
    assign o_ctl.take      = take;
    assign o_ctl.res_valid = i_valid && res_raw;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            dehw_pkg::PH_HEADER: begin
                if (!ext) begin
                    n_phase = (last || short_len == '0) ? dehw_pkg::PH_HEADER
                                                        : dehw_pkg::PH_PAYLOAD;
                end else begin
                    n_phase = last ? dehw_pkg::PH_HEADER : dehw_pkg::PH_TYPE;
                end
            end
            dehw_pkg::PH_TYPE: begin
                if (!ext) begin
                    n_phase = (last || r_pending_length == '0) ? dehw_pkg::PH_HEADER
                                                               : dehw_pkg::PH_PAYLOAD;
                end else if (count_step >= MaxCount) begin
                    n_phase = last ? dehw_pkg::PH_HEADER : dehw_pkg::PH_DISCARD;
                end else begin
                    n_phase = last ? dehw_pkg::PH_HEADER : dehw_pkg::PH_TYPE;
                end
            end
            dehw_pkg::PH_PAYLOAD: begin
                n_phase = (last || left_step == '0) ? dehw_pkg::PH_HEADER
                                                    : dehw_pkg::PH_PAYLOAD;
            end
            dehw_pkg::PH_DISCARD: begin
                n_phase = last ? dehw_pkg::PH_HEADER : dehw_pkg::PH_DISCARD;
            end
            default: begin
                n_phase = dehw_pkg::PH_HEADER;
            end
        endcase
    end

    // result and working registers
    always_comb begin
        n_type_accum      = r_type_accum;
        n_pending_length  = r_pending_length;
        n_type_byte_count = r_type_byte_count;
        n_payload_left    = r_payload_left;
        res_raw           = 1'b0;
        o_res             = '0;
        case (r_phase)
            dehw_pkg::PH_HEADER: begin
                if (!ext) begin
                    // one-byte header
                    res_raw = 1'b1;
                    if (last && short_len != '0) begin
                        o_res.kind       = dehw_pkg::KIND_ERROR;
                        o_res.error_code = dehw_pkg::ERR_IN_PAYLOAD;
                    end else begin
                        o_res.kind         = dehw_pkg::KIND_HEADER;
                        o_res.elem_type    = {52'd0, b[3:0]};
                        o_res.elem_length  = short_len;
                        o_res.header_bytes = 4'd1;
                    end
                    n_payload_left = short_len;
                end else begin
                    // extended header: type bytes follow
                    n_pending_length  = b[6:0];
                    n_type_accum      = '0;
                    n_type_byte_count = '0;
                    if (last) begin
                        res_raw          = 1'b1;
                        o_res.kind       = dehw_pkg::KIND_ERROR;
                        o_res.error_code = dehw_pkg::ERR_IN_HEADER;
                    end
                end
            end
            dehw_pkg::PH_TYPE: begin
                n_type_accum      = accum_step;
                n_type_byte_count = count_step;
                if (!ext) begin
                    // final type byte
                    res_raw = 1'b1;
                    if (last && r_pending_length != '0) begin
                        o_res.kind       = dehw_pkg::KIND_ERROR;
                        o_res.error_code = dehw_pkg::ERR_IN_PAYLOAD;
                    end else begin
                        o_res.kind         = dehw_pkg::KIND_HEADER;
                        o_res.elem_type    = accum_step;
                        o_res.elem_length  = r_pending_length;
                        o_res.header_bytes = count_step + 4'd1;
                    end
                    n_payload_left = r_pending_length;
                end else if (count_step >= MaxCount) begin
                    res_raw          = 1'b1;
                    o_res.kind       = dehw_pkg::KIND_ERROR;
                    o_res.error_code = dehw_pkg::ERR_TYPE_LONG;
                end else if (last) begin
                    res_raw          = 1'b1;
                    o_res.kind       = dehw_pkg::KIND_ERROR;
                    o_res.error_code = dehw_pkg::ERR_IN_HEADER;
                end
            end
            dehw_pkg::PH_PAYLOAD: begin
                n_payload_left = left_step;
                res_raw        = 1'b1;
                if (last && left_step != '0) begin
                    o_res.kind       = dehw_pkg::KIND_ERROR;
                    o_res.error_code = dehw_pkg::ERR_IN_PAYLOAD;
                end else begin
                    o_res.kind          = dehw_pkg::KIND_PAYLOAD;
                    o_res.payload_value = b;
                end
            end
            dehw_pkg::PH_DISCARD: begin
                if (last) begin
                    res_raw    = 1'b1;
                    o_res.kind = dehw_pkg::KIND_END;
                end
            end
            default: begin
                res_raw = 1'b0;
            end
        endcase
        o_res.end_of_buffer = last && res_raw;
        // the last byte returns everything to reset values
        if (last) begin
            n_type_accum      = '0;
            n_pending_length  = '0;
            n_type_byte_count = '0;
            n_payload_left    = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= dehw_pkg::PH_HEADER;
            r_type_accum      <= '0;
            r_pending_length  <= '0;
            r_type_byte_count <= '0;
            r_payload_left    <= '0;
        end else if (take) begin
            r_phase           <= n_phase;
            r_type_accum      <= n_type_accum;
            r_pending_length  <= n_pending_length;
            r_type_byte_count <= n_type_byte_count;
            r_payload_left    <= n_payload_left;
        end
    end

`ifndef ASSERT_OFF
    // the last byte of a buffer leaves the walker waiting for a header
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && last |=> r_phase == dehw_pkg::PH_HEADER && r_payload_left == '0)
        else $error("walker state not cleared after last byte");

    // payload phase always owes at least one byte
    a_payload_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dehw_pkg::PH_PAYLOAD |-> r_payload_left != '0)
        else $error("payload phase with nothing left");

    // type byte count stays below the limit while collecting type bytes
    a_type_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dehw_pkg::PH_TYPE |-> r_type_byte_count < MaxCount)
        else $error("type byte count passed the limit");

    // discarding gives no result until the last byte
    a_discard_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_phase == dehw_pkg::PH_DISCARD && !last |-> !o_ctl.res_valid)
        else $error("result emitted while discarding");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/dehw_out_reg.sv -----
// dehw_out_reg: result register in front of the output channel
// depends on dehw_pkg
`default_nettype none

module dehw_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  dehw_pkg::t_out_item  i_data,
    input  wire                  i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output dehw_pkg::t_out_item  o_data
);

    logic                r_valid;
    dehw_pkg::t_out_item r_data;

    // slot usable when empty or drained this cycle
    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hw/rtl/data_element_header_walker.sv -----
// data_element_header_walker: top level, input register, walker, result register
// depends on dehw_pkg, dehw_stream_if, dehw_in_reg, dehw_walker, dehw_out_reg
//
//   channel  dir  payload                                   handshake
//   i_in     in   data_byte, last_byte                      valid/ready
//   o_out    out  kind, elem_type, elem_length,             valid/ready
//                 header_bytes, payload_value,
//                 error_code, end_of_buffer
//
// one byte per cycle unless the output stalls; results come from the result register
// the rate is set by the walker updating its phase for each byte in a single pass
// reset (synchronous, active low) empties both registers and returns to header phase
// a stalled output holds its result while one more byte waits in the input register
`default_nettype none

module data_element_header_walker #(
    parameter int MAX_TYPE_BYTES = dehw_pkg::MAX_TYPE_BYTES
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    dehw_stream_if.sink    i_in,
    dehw_stream_if.source  o_out
);

    logic                 in_valid;
    dehw_pkg::t_in_item   in_data;
    dehw_pkg::t_walk_ctl  walk_ctl;
    dehw_pkg::t_out_item  walk_res;
    logic                 out_free;

    // input register
    dehw_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_data  (i_in.data),
        .o_ready (i_in.ready),
        .i_take  (walk_ctl.take),
        .o_valid (in_valid),
        .o_data  (in_data)
    );

    // header and payload walker
    dehw_walker #(
        .MAX_TYPE_BYTES (MAX_TYPE_BYTES)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_data     (in_data),
        .i_out_free (out_free),
        .o_ctl      (walk_ctl),
        .o_res      (walk_res)
    );

    // result register
    dehw_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (walk_ctl.take && walk_ctl.res_valid),
        .i_data  (walk_res),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_data  (o_out.data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_data_element_header_walker.sv -----
`timescale 1ns / 1ps
// tb_data_element_header_walker: self-checking bench for the data element header walker
// depends on dehw_pkg, dehw_stream_if and the data_element_header_walker rtl

module tb_data_element_header_walker;

    localparam int TYPE_LIMIT = dehw_pkg::MAX_TYPE_BYTES;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 650;

    // walker model plus the queue of results it still owes
    class element_scoreboard;
        dehw_pkg::t_phase                 phase;
        logic [dehw_pkg::TYPE_W-1:0]      type_acc;
        logic [dehw_pkg::LEN_W-1:0]       hdr_len;
        logic [dehw_pkg::HB_W-1:0]        type_cnt;
        logic [dehw_pkg::LEN_W-1:0]       pay_left;
        dehw_pkg::t_out_item              owed_q[$];
        int                               fail_count;

        function new();
            clear_walk();
            fail_count = 0;
        endfunction

        function void clear_walk();
            phase    = dehw_pkg::PH_HEADER;
            type_acc = '0;
            hdr_len  = '0;
            type_cnt = '0;
            pay_left = '0;
        endfunction

        // header done: emit it, or a payload error if the buffer stops here
        function void close_header(logic [dehw_pkg::TYPE_W-1:0] t,
                                   logic [dehw_pkg::LEN_W-1:0] len,
                                   logic [dehw_pkg::HB_W-1:0] hb, logic last);
            dehw_pkg::t_out_item r;
            r = '0;
            if (last && len != 0) begin
                r.kind       = dehw_pkg::KIND_ERROR;
                r.error_code = dehw_pkg::ERR_IN_PAYLOAD;
            end else begin
                r.kind         = dehw_pkg::KIND_HEADER;
                r.elem_type    = t;
                r.elem_length  = len;
                r.header_bytes = hb;
            end
            r.end_of_buffer = last;
            if (last) begin
                clear_walk();
            end else if (len != 0) begin
                phase    = dehw_pkg::PH_PAYLOAD;
                pay_left = len;
            end else begin
                phase = dehw_pkg::PH_HEADER;
            end
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void raise_error(logic [1:0] code, logic last);
            dehw_pkg::t_out_item r;
            r = '0;
            r.kind          = dehw_pkg::KIND_ERROR;
            r.error_code    = code;
            r.end_of_buffer = last;
            if (last) begin
                clear_walk();
            end else begin
                phase = dehw_pkg::PH_DISCARD;
            end
            owed_q.insert(owed_q.size(), r);
        endfunction

        // one accepted byte request
        function void log_byte(logic [7:0] b, logic last);
            dehw_pkg::t_out_item r;
            r = '0;
            case (phase)
                dehw_pkg::PH_HEADER: begin
                    if (!b[dehw_pkg::EXT_BIT]) begin
                        close_header({52'd0, b[3:0]}, {4'd0, b[6:4]}, 4'd1, last);
                    end else begin
                        hdr_len  = b[6:0];
                        type_acc = '0;
                        type_cnt = '0;
                        phase    = dehw_pkg::PH_TYPE;
                        if (last) raise_error(dehw_pkg::ERR_IN_HEADER, 1'b1);
                    end
                end
                dehw_pkg::PH_TYPE: begin
                    type_acc = {type_acc[dehw_pkg::TYPE_W-8:0], b[6:0]};
                    type_cnt = type_cnt + 4'd1;
                    if (!b[dehw_pkg::EXT_BIT]) begin
                        close_header(type_acc, hdr_len, type_cnt + 4'd1, last);
                    end else if (type_cnt >= TYPE_LIMIT) begin
                        raise_error(dehw_pkg::ERR_TYPE_LONG, last);
                    end else if (last) begin
                        raise_error(dehw_pkg::ERR_IN_HEADER, 1'b1);
                    end
                end
                dehw_pkg::PH_PAYLOAD: begin
                    pay_left = pay_left - 7'd1;
                    if (last && pay_left != 0) begin
                        r.kind       = dehw_pkg::KIND_ERROR;
                        r.error_code = dehw_pkg::ERR_IN_PAYLOAD;
                    end else begin
                        r.kind          = dehw_pkg::KIND_PAYLOAD;
                        r.payload_value = b;
                    end
                    r.end_of_buffer = last;
                    owed_q.insert(owed_q.size(), r);
                    if (last) begin
                        clear_walk();
                    end else if (pay_left == 0) begin
                        phase = dehw_pkg::PH_HEADER;
                    end
                end
                default: begin
                    // rest of an errored buffer is dropped until its last byte
                    if (last) begin
                        r.kind          = dehw_pkg::KIND_END;
                        r.end_of_buffer = 1'b1;
                        owed_q.insert(owed_q.size(), r);
                        clear_walk();
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_result(dehw_pkg::t_out_item got);
            dehw_pkg::t_out_item want;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result kind %0d with nothing owed", got.kind));
                return;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.elem_type !== want.elem_type)
                report_mismatch($sformatf("elem_type %h want %h",
                                          got.elem_type, want.elem_type));
            if (got.elem_length !== want.elem_length)
                report_mismatch($sformatf("elem_length %0d want %0d",
                                          got.elem_length, want.elem_length));
            if (got.header_bytes !== want.header_bytes)
                report_mismatch($sformatf("header_bytes %0d want %0d",
                                          got.header_bytes, want.header_bytes));
            if (got.payload_value !== want.payload_value)
                report_mismatch($sformatf("payload_value %h want %h",
                                          got.payload_value, want.payload_value));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code %0d want %0d",
                                          got.error_code, want.error_code));
            if (got.end_of_buffer !== want.end_of_buffer)
                report_mismatch($sformatf("end_of_buffer %0d want %0d",
                                          got.end_of_buffer, want.end_of_buffer));
        endtask

        task check_drained();
            if (owed_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", owed_q.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    dehw_stream_if #(.T(dehw_pkg::t_in_item))  in_if ();
    dehw_stream_if #(.T(dehw_pkg::t_out_item)) out_if ();

    data_element_header_walker #(
        .MAX_TYPE_BYTES(TYPE_LIMIT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    element_scoreboard sb = new();

    logic [7:0] buf_q[$];
    int         sent_bytes;
    bit         no_gaps;
    bit         hold_req;
    int         idle_cycles;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one byte request and wait until it is taken
    task automatic put_byte(logic [7:0] b, logic last);
        int                 gap;
        dehw_pkg::t_in_item item;
        gap = pick_gap();
        item.data_byte = b;
        item.last_byte = last;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.log_byte(b, last);
        sent_bytes++;
    endtask

    // send the queued buffer, last flag on its final byte
    task automatic send_buf();
        for (int i = 0; i < buf_q.size(); i++)
            put_byte(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
    endtask

    // one element with random content, well-formed but for an occasional overlong type run
    task automatic add_element();
        int          len;
        int          ntype;
        int          r;
        logic [31:0] rnd;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            len = $urandom_range(0, 7);
            rnd = $urandom;
            buf_q.insert(buf_q.size(), {1'b0, len[2:0], rnd[3:0]});
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) len = $urandom_range(64, 127);
            else if (r < 10) len = $urandom_range(9, 63);
            else len = $urandom_range(0, 8);
            buf_q.insert(buf_q.size(), {1'b1, len[6:0]});
            // some type runs overflow the limit
            if ($urandom_range(0, 19) == 0) ntype = $urandom_range(TYPE_LIMIT + 1, TYPE_LIMIT + 3);
            else ntype = $urandom_range(1, TYPE_LIMIT);
            for (int i = 0; i < ntype; i++) begin
                rnd = $urandom;
                buf_q.insert(buf_q.size(), {i != ntype - 1, rnd[6:0]});
            end
        end
        for (int i = 0; i < len; i++) begin
            rnd = $urandom;
            buf_q.insert(buf_q.size(), rnd[7:0]);
        end
    endtask

    // random buffer: mostly well-formed, some cut short, some plain noise
    task automatic build_buffer();
        int          r;
        int          n;
        int          cut;
        logic [31:0] rnd;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                rnd = $urandom;
                buf_q.insert(buf_q.size(), rnd[7:0]);
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_element();
            if ($urandom_range(0, 99) < 15) begin
                cut = $urandom_range(1, buf_q.size());
                while (buf_q.size() > cut) void'(buf_q.pop_back());
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int   stall_left;
        int   hold_left;
        logic rdy;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                rdy        = (stall_left == 0);
            end else begin
                rdy = 1'b1;
            end
            out_if.ready <= rdy;
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("** data_element_header_walker: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int nbuf;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        sent_bytes   = 0;
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        idle_cycles  = 0;
        nbuf         = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-byte header closing the buffer
        buf_q = '{8'h00};
        send_buf();
        // short header with a payload owed on the last byte
        buf_q = '{8'h10};
        send_buf();
        // buffer ends on the first extended header byte
        buf_q = '{8'h8F};
        send_buf();
        // buffer ends inside the type bytes
        buf_q = '{8'h80, 8'h81};
        send_buf();
        // payload cut short
        buf_q = '{8'h82, 8'h05, 8'hAA};
        send_buf();
        // widest type: all 56 bits set, nine header bytes
        buf_q = '{8'h80};
        repeat (TYPE_LIMIT - 1) buf_q.insert(buf_q.size(), 8'hFF);
        buf_q.insert(buf_q.size(), 8'h7F);
        send_buf();
        // type run too long, hitting on the last byte
        buf_q = '{8'hFF};
        repeat (TYPE_LIMIT) buf_q.insert(buf_q.size(), 8'hFF);
        send_buf();

        sent_bytes = 0;
        while (sent_bytes < RANDOM_ITEMS) begin
            if (nbuf == 10) hold_req = 1'b1;
            no_gaps = (nbuf >= 30 && nbuf < 45);
            build_buffer();
            send_buf();
            nbuf++;
        end
        no_gaps = 1'b0;
        in_if.valid <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.check_drained();
        if (sb.fail_count == 0) begin
            $display("** data_element_header_walker: PASSED **");
        end else begin
            $display("** data_element_header_walker: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dehw_pkg.sv
hw/rtl/dehw_stream_if.sv
hw/rtl/dehw_in_reg.sv
hw/rtl/dehw_walker.sv
hw/rtl/dehw_out_reg.sv
hw/rtl/data_element_header_walker.sv
tb/sv/tb_data_element_header_walker.sv
